// File: rtl/sorted_timer_queue_core_assert.svh
// Assertion macros used by the sorted timer queue core.
`ifndef SORTED_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Operation, result and slot mode codes used by the timer queue core and its testbench.
// ----------------------------------------------------------------------------
package stq_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_BIND  = 3'd2,
        OP_ARM   = 3'd3,
        OP_TICK  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_UNUSED = 2'd0,
        MODE_IDLE   = 2'd1,
        MODE_ARMED  = 2'd2
    } mode_t;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam int MAX_RESULTS = 32;

endpackage

// File: rtl/stq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer queue RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sorted_timer_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue core
// Pool of timer slots with a deadline-sorted list of armed slots.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start, busy             op, slot, channel, tag, timeout
// result    out        result_strobe (1 cycle) kind, slot_index, channel_out,
//                                              tag_out, last
//
// One command is worked at a time; busy is high until its last beat is out.
// Allocate scans the slot modes, one slot a cycle. Arm walks the list from
// the tail, moving each entry whose deadline is not earlier one place back;
// free walks the whole list and closes the gap. A tick fires due slots from
// the head, then compacts the remaining entries; the list RAM has a single
// read port. Reset clears the slot modes and the control registers at once;
// the RAM contents are left as they are.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_core_assert.svh"

module sorted_timer_queue_core #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [4:0]  slot,
    input  logic [3:0]  channel,
    input  logic [7:0]  tag,
    input  logic [31:0] timeout,
    output logic        result_strobe,
    output logic [1:0]  kind,
    output logic [4:0]  slot_index,
    output logic [3:0]  channel_out,
    output logic [7:0]  tag_out,
    output logic        last
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int FIRE_MAX = (TIMER_SLOTS < stq_pkg::MAX_RESULTS) ?
                              TIMER_SLOTS : stq_pkg::MAX_RESULTS;

    typedef enum logic [3:0] {
        S_IDLE, S_ALLOC, S_UNQ_A, S_UNQ_B, S_REF_A, S_REF_B, S_REF_C,
        S_ENQ_A, S_ENQ_B, S_ENQ_C, S_TK_A, S_TK_B, S_TK_C, S_TK_END,
        S_CP_A, S_CP_B
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   fired_reg, fired_next;
    logic [31:0]     tick_reg, tick_next;
    logic [31:0]     nxt_reg, nxt_next;
    logic [4:0]      slot_reg, slot_next;
    logic [31:0]     dl_new_reg, dl_new_next;
    logic [SW-1:0]   cur_reg, cur_next;
    logic            found_reg, found_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [1:0]      pend_kind_reg, pend_kind_next;
    logic [4:0]      pend_slot_reg, pend_slot_next;
    logic [3:0]      pend_ch_reg, pend_ch_next;
    logic [7:0]      pend_tag_reg, pend_tag_next;
    logic            strobe_reg, strobe_next;
    logic [1:0]      kind_reg, kind_next;
    logic [4:0]      sidx_reg, sidx_next;
    logic [3:0]      ch_reg, ch_next;
    logic [7:0]      tag_reg, tag_next;
    logic            last_reg, last_next;
    logic [1:0]      mode_reg [TIMER_SLOTS];

    logic            mode_we;
    logic [SW-1:0]   mode_wa;
    logic [1:0]      mode_wd;
    logic [SW-1:0]   mode_ra;
    logic [1:0]      mode_q;

    logic            ord_we;
    logic [SW-1:0]   ord_wa, ord_wd, ord_ra, ord_q;
    logic            dl_we;
    logic [SW-1:0]   dl_wa;
    logic [31:0]     dl_wd, dl_q;
    logic [SW-1:0]   slot_ra;
    logic            meta_we;
    logic [SW-1:0]   meta_wa;
    logic [11:0]     meta_wd, meta_q;

    logic            accept;
    logic            in_ok;
    logic [SW-1:0]   in_idx;
    logic [SW-1:0]   s_idx;
    logic [31:0]     tick_inc;
    logic [CW-1:0]   cp_pos;

    stq_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_order (
        .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
        .raddr(ord_ra), .rdata(ord_q)
    );

    stq_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_deadline (
        .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd),
        .raddr(slot_ra), .rdata(dl_q)
    );

    stq_ram #(.WIDTH(12), .DEPTH(TIMER_SLOTS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(slot_ra), .rdata(meta_q)
    );

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign in_ok         = (32'(slot) < TIMER_SLOTS);
    assign in_idx        = SW'(slot);
    assign s_idx         = SW'(slot_reg);
    assign tick_inc      = tick_reg + 32'd1;
    assign cp_pos        = idx_reg + fired_reg;
    assign mode_ra       = (state_reg == S_IDLE) ? in_idx : idx_reg[SW-1:0];
    assign mode_q        = mode_reg[mode_ra];
    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign slot_index    = sidx_reg;
    assign channel_out   = ch_reg;
    assign tag_out       = tag_reg;
    assign last          = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        fired_next      = fired_reg;
        tick_next       = tick_reg;
        nxt_next        = nxt_reg;
        slot_next       = slot_reg;
        dl_new_next     = dl_new_reg;
        cur_next        = cur_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        pend_ch_next    = pend_ch_reg;
        pend_tag_next   = pend_tag_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        sidx_next       = sidx_reg;
        ch_next         = ch_reg;
        tag_next        = tag_reg;
        last_next       = last_reg;
        mode_we         = 1'b0;
        mode_wa         = mode_ra;
        mode_wd         = stq_pkg::MODE_UNUSED;
        ord_we          = 1'b0;
        ord_wa          = idx_reg[SW-1:0];
        ord_wd          = s_idx;
        ord_ra          = idx_reg[SW-1:0];
        dl_we           = 1'b0;
        dl_wa           = in_idx;
        dl_wd           = timeout + tick_reg;
        slot_ra         = ord_q;
        meta_we         = 1'b0;
        meta_wa         = in_idx;
        meta_wd         = {channel, tag};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next      = slot;
                    pend_kind_next = stq_pkg::KIND_ACK;
                    pend_slot_next = slot;
                    pend_ch_next   = 4'd0;
                    pend_tag_next  = 8'd0;
                    strobe_next    = 1'b1;
                    kind_next      = stq_pkg::KIND_ACK;
                    sidx_next      = slot;
                    ch_next        = 4'd0;
                    tag_next       = 8'd0;
                    last_next      = 1'b1;
                    unique case (op)
                        stq_pkg::OP_ALLOC:
                        begin
                            strobe_next = 1'b0;
                            idx_next    = '0;
                            state_next  = S_ALLOC;
                        end
                        stq_pkg::OP_FREE:
                        begin
                            if (in_ok)
                            begin
                                mode_we = 1'b1;
                                mode_wd = stq_pkg::MODE_UNUSED;
                                if (mode_q == stq_pkg::MODE_ARMED)
                                begin
                                    strobe_next = 1'b0;
                                    idx_next    = '0;
                                    found_next  = 1'b0;
                                    state_next  = S_UNQ_A;
                                end
                            end
                        end
                        stq_pkg::OP_BIND:
                        begin
                            meta_we = in_ok;
                        end
                        stq_pkg::OP_ARM:
                        begin
                            if (!in_ok || mode_q != stq_pkg::MODE_IDLE)
                            begin
                                kind_next = stq_pkg::KIND_REJECT;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                                dl_we       = 1'b1;
                                mode_we     = 1'b1;
                                mode_wd     = stq_pkg::MODE_ARMED;
                                dl_new_next = dl_wd;
                                idx_next    = cnt_reg;
                                state_next  = S_ENQ_A;
                            end
                        end
                        stq_pkg::OP_TICK:
                        begin
                            tick_next      = tick_inc;
                            sidx_next      = 5'd0;
                            pend_slot_next = 5'd0;
                            if (nxt_reg <= tick_inc)
                            begin
                                strobe_next     = 1'b0;
                                pend_valid_next = 1'b0;
                                idx_next        = '0;
                                state_next      = S_TK_A;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                ch_next     = 4'd0;
                tag_next    = 8'd0;
                if (mode_q == stq_pkg::MODE_UNUSED)
                begin
                    mode_we    = 1'b1;
                    mode_wd    = stq_pkg::MODE_IDLE;
                    kind_next  = stq_pkg::KIND_ACK;
                    sidx_next  = 5'(idx_reg);
                    state_next = S_IDLE;
                end
                else if (32'(idx_reg) == TIMER_SLOTS - 1)
                begin
                    kind_next  = stq_pkg::KIND_FULL;
                    sidx_next  = 5'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    strobe_next = 1'b0;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            S_UNQ_A:
            begin
                state_next = S_UNQ_B;
            end
            S_UNQ_B:
            begin
                if (found_reg)
                begin
                    ord_we = 1'b1;
                    ord_wa = SW'(idx_reg - 1'b1);
                    ord_wd = ord_q;
                end
                found_next = found_reg || (ord_q == s_idx);
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    if (found_next)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    state_next = S_REF_A;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_UNQ_A;
                end
            end
            S_REF_A:
            begin
                ord_ra = '0;
                if (cnt_reg == '0)
                begin
                    nxt_next    = stq_pkg::ALL_ONES;
                    strobe_next = 1'b1;
                    kind_next   = pend_kind_reg;
                    sidx_next   = pend_slot_reg;
                    ch_next     = pend_ch_reg;
                    tag_next    = pend_tag_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_REF_B;
                end
            end
            S_REF_B:
            begin
                state_next = S_REF_C;
            end
            S_REF_C:
            begin
                nxt_next    = dl_q;
                strobe_next = 1'b1;
                kind_next   = pend_kind_reg;
                sidx_next   = pend_slot_reg;
                ch_next     = pend_ch_reg;
                tag_next    = pend_tag_reg;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_ENQ_A:
            begin
                ord_ra = SW'(idx_reg - 1'b1);
                if (idx_reg == '0)
                begin
                    ord_we      = 1'b1;
                    ord_wa      = '0;
                    nxt_next    = dl_new_reg;
                    cnt_next    = cnt_reg + 1'b1;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_ENQ_B;
                end
            end
            S_ENQ_B:
            begin
                cur_next   = ord_q;
                state_next = S_ENQ_C;
            end
            S_ENQ_C:
            begin
                ord_we = 1'b1;
                if (dl_q >= dl_new_reg)
                begin
                    ord_wd     = cur_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_ENQ_A;
                end
                else
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_TK_A:
            begin
                if (idx_reg == cnt_reg || idx_reg == CW'(FIRE_MAX))
                begin
                    state_next = S_TK_END;
                end
                else
                begin
                    state_next = S_TK_B;
                end
            end
            S_TK_B:
            begin
                cur_next   = ord_q;
                state_next = S_TK_C;
            end
            S_TK_C:
            begin
                slot_ra = cur_reg;
                if (dl_q > tick_reg)
                begin
                    state_next = S_TK_END;
                end
                else
                begin
                    mode_we         = 1'b1;
                    mode_wa         = cur_reg;
                    mode_wd         = stq_pkg::MODE_IDLE;
                    strobe_next     = pend_valid_reg;
                    kind_next       = pend_kind_reg;
                    sidx_next       = pend_slot_reg;
                    ch_next         = pend_ch_reg;
                    tag_next        = pend_tag_reg;
                    last_next       = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_kind_next  = stq_pkg::KIND_FIRED;
                    pend_slot_next  = 5'(cur_reg);
                    pend_ch_next    = meta_q[11:8];
                    pend_tag_next   = meta_q[7:0];
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_TK_A;
                end
            end
            S_TK_END:
            begin
                fired_next = idx_reg;
                cnt_next   = cnt_reg - idx_reg;
                idx_next   = '0;
                state_next = S_CP_A;
            end
            S_CP_A:
            begin
                ord_ra = cp_pos[SW-1:0];
                if (idx_reg == cnt_reg)
                begin
                    state_next = S_REF_A;
                end
                else
                begin
                    state_next = S_CP_B;
                end
            end
            S_CP_B:
            begin
                ord_we     = 1'b1;
                ord_wd     = ord_q;
                idx_next   = idx_reg + 1'b1;
                state_next = S_CP_A;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            fired_reg      <= '0;
            tick_reg       <= '0;
            nxt_reg        <= stq_pkg::ALL_ONES;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                mode_reg[i] <= stq_pkg::MODE_UNUSED;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            fired_reg      <= fired_next;
            tick_reg       <= tick_next;
            nxt_reg        <= nxt_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            if (mode_we)
            begin
                mode_reg[mode_wa] <= mode_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        dl_new_reg    <= dl_new_next;
        cur_reg       <= cur_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        pend_ch_reg   <= pend_ch_next;
        pend_tag_reg  <= pend_tag_next;
        kind_reg      <= kind_next;
        sidx_reg      <= sidx_next;
        ch_reg        <= ch_next;
        tag_reg       <= tag_next;
        last_reg      <= last_next;
    end

    `STQ_ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, 32'(cnt_reg) <= TIMER_SLOTS)
    `STQ_ASSERT_IMPLY(a_more_beats, clk, rst_n, strobe_reg && !last_reg, busy)
    `STQ_ASSERT_IMPLY(a_empty_next, clk, rst_n, !busy && cnt_reg == '0,
                      nxt_reg == stq_pkg::ALL_ONES)
    `STQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept && op == stq_pkg::OP_ALLOC,
                     busy)

endmodule

// File: bench/sorted_timer_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted timer queue core testbench
// Drives directed and random commands through the start/busy handshake,
// predicts every result beat with a behavioral copy of the slot pool and the
// deadline-ordered list, and checks each strobed beat against the oldest
// prediction.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core_tb;

    localparam int          SLOTS       = 32;
    localparam int          RANDOM_CMDS = 364;
    localparam int          STALL_LIMIT = 4000;
    localparam logic [2:0]  OP_RSVD_LO  = 3'd5;
    localparam logic [2:0]  OP_RSVD_HI  = 3'd7;

    typedef struct packed {
        stq_pkg::kind_t kind;
        logic [4:0]     slot_index;
        logic [3:0]     channel;
        logic [7:0]     tag;
        logic           last;
    } beat_t;

    typedef struct {
        logic [2:0]     op;
        logic [4:0]     slot;
        logic [3:0]     channel;
        logic [7:0]     tag;
        logic [31:0]    timeout;
        int             reps;
        bit             typed;
        stq_pkg::kind_t kind;
        logic [4:0]     slot_index;
    } cmd_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [4:0]  slot;
    logic [3:0]  channel;
    logic [7:0]  tag;
    logic [31:0] timeout;
    logic        result_strobe;
    logic [1:0]  kind;
    logic [4:0]  slot_index;
    logic [3:0]  channel_out;
    logic [7:0]  tag_out;
    logic        last;

    stq_pkg::mode_t pool_mode [SLOTS];
    logic [3:0]  pool_channel [SLOTS];
    logic [7:0]  pool_tag [SLOTS];
    logic [31:0] pool_deadline [SLOTS];
    bit          pool_bound [SLOTS];
    int          deadline_order [$];
    logic [31:0] tick_now;

    beat_t       pending_beats [$];
    beat_t       fresh_beats [$];
    cmd_row_t    cmd_table [$];
    int          mismatches;
    int          quiet_cycles;

    sorted_timer_queue_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .slot          (slot),
        .channel       (channel),
        .tag           (tag),
        .timeout       (timeout),
        .result_strobe (result_strobe),
        .kind          (kind),
        .slot_index    (slot_index),
        .channel_out   (channel_out),
        .tag_out       (tag_out),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic beat_t make_beat(stq_pkg::kind_t k, logic [4:0] s, logic [3:0] c,
                                        logic [7:0] t, logic l);
        beat_t b;
        b.kind       = k;
        b.slot_index = s;
        b.channel    = c;
        b.tag        = t;
        b.last       = l;
        return b;
    endfunction

    task automatic predict_command(logic [2:0] c_op, logic [4:0] c_slot, logic [3:0] c_ch,
                                   logic [7:0] c_tag, logic [31:0] c_timeout);
        int          pos;
        int          fired;
        int          s;
        logic [31:0] dl;
        fresh_beats.delete();
        case (c_op)
            stq_pkg::OP_ALLOC:
            begin
                pos = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (pos < 0 && pool_mode[i] == stq_pkg::MODE_UNUSED)
                        pos = i;
                if (pos < 0)
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_FULL, 5'd0, 4'd0, 8'd0,
                                                    1'b1));
                else
                begin
                    pool_mode[pos] = stq_pkg::MODE_IDLE;
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, pos[4:0], 4'd0, 8'd0,
                                                    1'b1));
                end
            end
            stq_pkg::OP_FREE:
            begin
                if (pool_mode[c_slot] == stq_pkg::MODE_ARMED)
                    for (int i = 0; i < deadline_order.size(); i++)
                        if (deadline_order[i] == c_slot)
                        begin
                            deadline_order.delete(i);
                            break;
                        end
                pool_mode[c_slot] = stq_pkg::MODE_UNUSED;
                fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, c_slot, 4'd0, 8'd0, 1'b1));
            end
            stq_pkg::OP_BIND:
            begin
                pool_channel[c_slot] = c_ch;
                pool_tag[c_slot]     = c_tag;
                pool_bound[c_slot]   = 1'b1;
                fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, c_slot, 4'd0, 8'd0, 1'b1));
            end
            stq_pkg::OP_ARM:
            begin
                if (pool_mode[c_slot] != stq_pkg::MODE_IDLE)
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_REJECT, c_slot, 4'd0, 8'd0,
                                                    1'b1));
                else
                begin
                    dl = c_timeout + tick_now;
                    pool_deadline[c_slot] = dl;
                    pool_mode[c_slot]     = stq_pkg::MODE_ARMED;
                    pos = deadline_order.size();
                    for (int i = deadline_order.size() - 1; i >= 0; i--)
                        if (pool_deadline[deadline_order[i]] >= dl)
                            pos = i;
                    deadline_order.insert(pos, int'(c_slot));
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, c_slot, 4'd0, 8'd0,
                                                    1'b1));
                end
            end
            stq_pkg::OP_TICK:
            begin
                tick_now = tick_now + 32'd1;
                fired = 0;
                while (deadline_order.size() > 0 && fired < stq_pkg::MAX_RESULTS
                       && pool_deadline[deadline_order[0]] <= tick_now)
                begin
                    s = deadline_order.pop_front();
                    pool_mode[s] = stq_pkg::MODE_IDLE;
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_FIRED, s[4:0],
                                                    pool_channel[s], pool_tag[s], 1'b0));
                    fired++;
                end
                if (fired == 0)
                    fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, 5'd0, 4'd0, 8'd0,
                                                    1'b1));
                else
                    fresh_beats[fired - 1].last = 1'b1;
            end
            default:
                fresh_beats.push_back(make_beat(stq_pkg::KIND_ACK, c_slot, 4'd0, 8'd0, 1'b1));
        endcase
    endtask

    task automatic add_row(logic [2:0] r_op, logic [4:0] r_slot, logic [3:0] r_ch,
                           logic [7:0] r_tag, logic [31:0] r_timeout, int r_reps,
                           bit r_typed, stq_pkg::kind_t r_kind, logic [4:0] r_index);
        cmd_row_t r;
        r.op         = r_op;
        r.slot       = r_slot;
        r.channel    = r_ch;
        r.tag        = r_tag;
        r.timeout    = r_timeout;
        r.reps       = r_reps;
        r.typed      = r_typed;
        r.kind       = r_kind;
        r.slot_index = r_index;
        cmd_table.push_back(r);
    endtask

    // Holds the command until the handshake takes it, predicts its beats, and
    // then leaves a random gap when the current burst has run out.
    task automatic issue_command(logic [2:0] c_op, logic [4:0] c_slot, logic [3:0] c_ch,
                                 logic [7:0] c_tag, logic [31:0] c_timeout, bit typed,
                                 stq_pkg::kind_t t_kind, logic [4:0] t_index,
                                 inout int burst);
        start   <= 1'b1;
        op      <= c_op;
        slot    <= c_slot;
        channel <= c_ch;
        tag     <= c_tag;
        timeout <= c_timeout;
        do
            @(posedge clk);
        while (busy);
        predict_command(c_op, c_slot, c_ch, c_tag, c_timeout);
        if (typed)
            fresh_beats[0] = make_beat(t_kind, t_index, 4'd0, 8'd0, 1'b1);
        foreach (fresh_beats[i])
            pending_beats.push_back(fresh_beats[i]);
        burst--;
        if (burst <= 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        end
    endtask

    function automatic logic [4:0] pick_slot();
        int tries;
        tries = 0;
        while (tries < 8)
        begin
            int s;
            s = $urandom_range(0, SLOTS - 1);
            if (pool_mode[s] != stq_pkg::MODE_UNUSED)
                return s[4:0];
            tries++;
        end
        return 5'($urandom_range(0, SLOTS - 1));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            beat_t got;
            got = make_beat(stq_pkg::kind_t'(kind), slot_index, channel_out, tag_out, last);
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat kind=%0d slot=%0d ch=%0d tag=%0h last=%0b",
                             $realtime, kind, slot_index, channel_out, tag_out, last);
            end
            else
            begin
                beat_t want;
                want = pending_beats.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: beat mismatch: expected kind=%0d slot=%0d ch=%0d ",
                                  "tag=%0h last=%0b, got kind=%0d slot=%0d ch=%0d tag=%0h ",
                                  "last=%0b"}, $realtime, want.kind, want.slot_index,
                                 want.channel, want.tag, want.last, kind, slot_index,
                                 channel_out, tag_out, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sorted_timer_queue_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          burst;
        int          pick;
        logic [2:0]  r_op;
        logic [4:0]  r_slot;
        logic [31:0] r_timeout;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = stq_pkg::OP_TICK;
        slot         = '0;
        channel      = '0;
        tag          = '0;
        timeout      = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        tick_now     = '0;
        burst        = 4;
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_mode[i]     = stq_pkg::MODE_UNUSED;
            pool_channel[i]  = '0;
            pool_tag[i]      = '0;
            pool_deadline[i] = '0;
            pool_bound[i]    = 1'b0;
        end

        add_row(stq_pkg::OP_ALLOC, 5'd0, 4'd0, 8'd0, 32'd0, 1, 1, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_TICK, 5'd0, 4'd0, 8'd0, 32'd0, 1, 1, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd31, 4'd0, 8'd0, 32'd5, 1, 1, stq_pkg::KIND_REJECT, 5'd31);
        add_row(stq_pkg::OP_ALLOC, 5'd0, 4'd0, 8'd0, 32'd0, 2, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_BIND, 5'd0, 4'hf, 8'hff, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_BIND, 5'd1, 4'h0, 8'h00, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_BIND, 5'd2, 4'ha, 8'h5a, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd0, 4'd0, 8'd0, 32'd2, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd1, 4'd0, 8'd0, 32'd2, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd2, 4'd0, 8'd0, stq_pkg::ALL_ONES, 1, 0,
                stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd0, 4'd0, 8'd0, 32'd1, 1, 1, stq_pkg::KIND_REJECT, 5'd0);
        add_row(stq_pkg::OP_TICK, 5'd0, 4'd0, 8'd0, 32'd0, 3, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd1, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ARM, 5'd0, 4'd0, 8'd0, 32'd10, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_FREE, 5'd0, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_TICK, 5'd0, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(OP_RSVD_LO, 5'd7, 4'd3, 8'd9, 32'd0, 1, 1, stq_pkg::KIND_ACK, 5'd7);
        add_row(OP_RSVD_HI, 5'd31, 4'hf, 8'hff, stq_pkg::ALL_ONES, 1, 1,
                stq_pkg::KIND_ACK, 5'd31);
        add_row(3'd6, 5'd16, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ALLOC, 5'd0, 4'd0, 8'd0, 32'd0, 30, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_ALLOC, 5'd0, 4'd0, 8'd0, 32'd0, 1, 1, stq_pkg::KIND_FULL, 5'd0);
        add_row(stq_pkg::OP_BIND, 5'd31, 4'h5, 8'ha5, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_FREE, 5'd31, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);
        add_row(stq_pkg::OP_FREE, 5'd3, 4'd0, 8'd0, 32'd0, 1, 0, stq_pkg::KIND_ACK, 5'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (cmd_table[i])
            repeat (cmd_table[i].reps)
                issue_command(cmd_table[i].op, cmd_table[i].slot, cmd_table[i].channel,
                              cmd_table[i].tag, cmd_table[i].timeout, cmd_table[i].typed,
                              cmd_table[i].kind, cmd_table[i].slot_index, burst);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 14)
                r_op = stq_pkg::OP_ALLOC;
            else if (pick < 24)
                r_op = stq_pkg::OP_FREE;
            else if (pick < 42)
                r_op = stq_pkg::OP_BIND;
            else if (pick < 68)
                r_op = stq_pkg::OP_ARM;
            else if (pick < 96)
                r_op = stq_pkg::OP_TICK;
            else
                r_op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
            r_slot = (r_op == stq_pkg::OP_ARM || r_op == stq_pkg::OP_FREE) ?
                     pick_slot() : 5'($urandom_range(0, SLOTS - 1));
            if (r_op == stq_pkg::OP_ARM && pool_mode[r_slot] == stq_pkg::MODE_IDLE
                && !pool_bound[r_slot])
                r_op = stq_pkg::OP_BIND;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                r_timeout = $urandom_range(0, 8);
            else if (pick < 9)
                r_timeout = $urandom_range(0, 64);
            else
                r_timeout = $urandom();
            issue_command(r_op, r_slot, 4'($urandom_range(0, 15)),
                          8'($urandom_range(0, 255)), r_timeout, 0, stq_pkg::KIND_ACK,
                          5'd0, burst);
        end
        start <= 1'b0;

        while (pending_beats.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && pending_beats.size() == 0)
            $display("sorted_timer_queue_core_tb: PASS");
        else
            $display("sorted_timer_queue_core_tb: FAIL");
        $finish;
    end

endmodule
